// File: hdl/hrhp_pkg.sv
// Package for the HTTP response head parser: phase and event codes, sizes.
// No dependencies.
package hrhp_pkg;

   localparam int unsigned HEAD_BYTES_MAX_DEF = 65536;
   localparam int unsigned CFG_W = 17;
   localparam logic [CFG_W-1:0] MAX_HEAD_RESET = 17'd4096;

   typedef enum logic [4:0] {
      PH_H, PH_T1, PH_T2, PH_P, PH_SLASH, PH_VER_FIRST, PH_VER,
      PH_CODE_FIRST, PH_CODE, PH_REASON, PH_LINE_LF,
      PH_HDR_START, PH_NAME, PH_VAL_BEFORE, PH_VAL, PH_HDR_LF, PH_END_LF,
      PH_DONE, PH_FAIL
   } phase_type;

   typedef enum logic [2:0] {
      EV_MORE = 3'd0, EV_STATUS = 3'd1, EV_HEADER = 3'd2,
      EV_DONE = 3'd3, EV_ERROR = 3'd4
   } event_type;

   localparam int unsigned CAND_CONN = 0;
   localparam int unsigned CAND_CLEN = 1;
   localparam int unsigned CAND_TENC = 2;

   localparam logic [1:0] BODY_NONE = 2'd0;
   localparam logic [1:0] BODY_CLEN = 2'd1;
   localparam logic [1:0] BODY_CHUNK = 2'd2;

   localparam logic [30:0] LEN_LIMIT = 31'h7FFF_FFFF;
   localparam logic [9:0] CODE_SAT = 10'd1000;
   localparam logic [16:0] FIELD_SAT = 17'h1FFFF;

   // parse state carried from one byte to the next
   typedef struct packed {
      phase_type   phase;
      logic [2:0]  flags;
      logic [16:0] field_len;
      logic [16:0] ver_len;
      logic [9:0]  code;
      logic [30:0] clen;
      logic [16:0] count;
      logic [1:0]  body;
      logic        keep;
   } parse_state_type;

   function automatic logic [7:0] lower(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
   endfunction

   // character of each candidate name at a position (lower case)
   function automatic logic [7:0] conn_char(input logic [4:0] p);
      case (p)
         5'd0: return "c"; 5'd1: return "o"; 5'd2: return "n"; 5'd3: return "n";
         5'd4: return "e"; 5'd5: return "c"; 5'd6: return "t"; 5'd7: return "i";
         5'd8: return "o"; 5'd9: return "n";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] clen_char(input logic [4:0] p);
      case (p)
         5'd0: return "c"; 5'd1: return "o"; 5'd2: return "n"; 5'd3: return "t";
         5'd4: return "e"; 5'd5: return "n"; 5'd6: return "t"; 5'd7: return "-";
         5'd8: return "l"; 5'd9: return "e"; 5'd10: return "n"; 5'd11: return "g";
         5'd12: return "t"; 5'd13: return "h";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] tenc_char(input logic [4:0] p);
      case (p)
         5'd0: return "t"; 5'd1: return "r"; 5'd2: return "a"; 5'd3: return "n";
         5'd4: return "s"; 5'd5: return "f"; 5'd6: return "e"; 5'd7: return "r";
         5'd8: return "-"; 5'd9: return "e"; 5'd10: return "n"; 5'd11: return "c";
         5'd12: return "o"; 5'd13: return "d"; 5'd14: return "i"; 5'd15: return "n";
         5'd16: return "g";
         default: return 8'h00;
      endcase
   endfunction

endpackage

// File: hdl/hrhp_step.sv
// One-byte parse step: combinational next state and event for a byte.
// Depends on hrhp_pkg.
module hrhp_step (
   input  hrhp_pkg::parse_state_type cur_st,
   input  logic [7:0]                c,
   input  logic                      start,
   input  logic [16:0]               limit,
   output hrhp_pkg::parse_state_type nxt_st,
   output hrhp_pkg::event_type       ev
);
   import hrhp_pkg::*;

   parse_state_type s;
   parse_state_type n;
   event_type       e;
   logic            digit;
   logic [3:0]      d;
   logic [7:0]      lc;
   logic [4:0]      pos;
   logic            fl_lt32;
   logic [2:0]      nf;
   logic [34:0]     clen_x10;
   logic [34:0]     clen_new;
   logic [13:0]     code_new;
   logic            printable;

   always_comb begin
      s = cur_st;
      if (start) begin
         s.phase = PH_H; s.flags = 3'b111; s.field_len = '0; s.ver_len = '0;
         s.code = '0; s.clen = '0; s.count = '0; s.body = BODY_NONE; s.keep = 1'b0;
      end
      digit = (c >= "0") && (c <= "9");
      d = c[3:0];
      lc = lower(c);
      printable = (c >= 8'd32) && (c <= 8'd126);
      code_new = 14'(s.code) * 14'd10 + 14'(d);
      clen_x10 = 35'(s.clen) * 35'd10;
      clen_new = clen_x10 + 35'(d);
      n = s;
      e = EV_MORE;
      // name position for candidate compare; positions past 31 never match
      fl_lt32 = (s.field_len < 17'd32);
      pos = s.field_len[4:0];
      nf = '0;
      if (s.phase == PH_DONE || s.phase == PH_FAIL) begin
         n = s;
         e = EV_ERROR;
      end else begin
         if (s.count != FIELD_SAT) n.count = s.count + 17'd1;
         case (s.phase)
            PH_H:  if (lc != "h") e = EV_ERROR; else n.phase = PH_T1;
            PH_T1: if (lc != "t") e = EV_ERROR; else n.phase = PH_T2;
            PH_T2: if (lc != "t") e = EV_ERROR; else n.phase = PH_P;
            PH_P:  if (lc != "p") e = EV_ERROR; else n.phase = PH_SLASH;
            PH_SLASH: begin
               if (c != "/") e = EV_ERROR;
               else begin
                  n.ver_len = 17'd5;
                  n.phase = PH_VER_FIRST;
               end
            end
            PH_VER_FIRST, PH_VER: begin
               if (c == " " && s.phase == PH_VER) n.phase = PH_CODE_FIRST;
               else if (!digit && c != ".") e = EV_ERROR;
               else begin
                  if (s.ver_len != FIELD_SAT) n.ver_len = s.ver_len + 17'd1;
                  n.phase = PH_VER;
               end
            end
            PH_CODE_FIRST, PH_CODE: begin
               if (c == " " && s.phase == PH_CODE) n.phase = PH_REASON;
               else if (!digit) e = EV_ERROR;
               else begin
                  n.code = (code_new > 14'(CODE_SAT)) ? CODE_SAT : code_new[9:0];
                  n.phase = PH_CODE;
               end
            end
            PH_REASON: if (c == 8'h0D) n.phase = PH_LINE_LF;
            PH_LINE_LF: begin
               if (c != 8'h0A || s.ver_len < 17'd8 || s.code < 10'd1 || s.code > 10'd999)
                  e = EV_ERROR;
               else begin
                  n.phase = PH_HDR_START;
                  e = EV_STATUS;
               end
            end
            PH_HDR_START, PH_NAME: begin
               if (s.phase == PH_HDR_START && c == 8'h0D) n.phase = PH_END_LF;
               else if (!printable) e = EV_ERROR;
               else if (s.phase == PH_NAME && c == ":") begin
                  nf[CAND_CONN] = s.flags[CAND_CONN] && s.field_len == 17'd10;
                  nf[CAND_CLEN] = s.flags[CAND_CLEN] && s.field_len == 17'd14;
                  nf[CAND_TENC] = s.flags[CAND_TENC] && s.field_len == 17'd17;
                  n.flags = nf;
                  n.field_len = '0;
                  if (nf[CAND_CLEN]) n.clen = '0;
                  n.phase = PH_VAL_BEFORE;
               end else begin
                  // first name byte restarts all candidates at position zero
                  if (s.phase == PH_HDR_START) begin
                     s.flags = 3'b111;
                     s.field_len = '0;
                     fl_lt32 = 1'b1;
                     pos = '0;
                  end
                  nf[CAND_CONN] = s.flags[CAND_CONN] && fl_lt32 && lc == conn_char(pos);
                  nf[CAND_CLEN] = s.flags[CAND_CLEN] && fl_lt32 && lc == clen_char(pos);
                  nf[CAND_TENC] = s.flags[CAND_TENC] && fl_lt32 && lc == tenc_char(pos);
                  n.flags = nf;
                  n.field_len = (s.field_len != FIELD_SAT) ? s.field_len + 17'd1 : s.field_len;
                  n.phase = PH_NAME;
               end
            end
            PH_VAL_BEFORE, PH_VAL: begin
               if (s.phase == PH_VAL_BEFORE && c == " ") n.phase = PH_VAL_BEFORE;
               else if (c == 8'h0D) n.phase = PH_HDR_LF;
               else begin
                  n.phase = PH_VAL;
                  if (s.field_len != FIELD_SAT) n.field_len = s.field_len + 17'd1;
                  if (s.flags[CAND_CLEN]) begin
                     if (!digit || clen_new > 35'(LEN_LIMIT)) e = EV_ERROR;
                     else n.clen = clen_new[30:0];
                  end
               end
            end
            PH_HDR_LF: begin
               if (c != 8'h0A) e = EV_ERROR;
               else if (s.flags[CAND_CLEN] && s.field_len == '0) e = EV_ERROR;
               else begin
                  if (s.flags[CAND_CONN] && s.field_len > 17'd5) n.keep = 1'b1;
                  if (s.flags[CAND_CLEN]) n.body = BODY_CLEN;
                  if (s.flags[CAND_TENC]) n.body = BODY_CHUNK;
                  n.phase = PH_HDR_START;
                  e = EV_HEADER;
               end
            end
            PH_END_LF: begin
               if (c != 8'h0A) e = EV_ERROR;
               else begin
                  n.phase = PH_DONE;
                  e = EV_DONE;
               end
            end
            default: e = EV_ERROR;
         endcase
         if (e != EV_DONE && e != EV_ERROR && n.count >= limit) e = EV_ERROR;
         if (e == EV_ERROR) n.phase = PH_FAIL;
      end
      nxt_st = n;
      ev = e;
   end
endmodule

// File: hdl/http_response_head_parser.sv
// HTTP response head parser, top level: input register, step logic, result register.
// Depends on hrhp_pkg and hrhp_step.
// A transferred byte waits in the input register; its result is then registered in the
// result register, which drives rsp_. Throughput: one byte per cycle; input stalls
// only when both the input and result registers hold items and the result is not taken.
// Reset: synchronous, active high; clears parse state, valids and sets the byte limit to 4096.
module http_response_head_parser #(
   parameter int unsigned HEAD_BYTES_MAX = hrhp_pkg::HEAD_BYTES_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_start_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_res,
   output logic [9:0]  rsp_resp_code,
   output logic [30:0] rsp_length_value,
   output logic [1:0]  rsp_body_kind,
   output logic        rsp_keep_alive,
   output logic [16:0] rsp_head_length,
   input  logic        csr_write_enable,
   input  logic [16:0] csr_write_data
);
   import hrhp_pkg::*;

   localparam logic [16:0] LIMIT_CAP = 17'(HEAD_BYTES_MAX > 17'h1FFFF ? 17'h1FFFF
                                                                      : HEAD_BYTES_MAX);

   logic [16:0]     max_head_ff;
   logic [16:0]     limit;
   // input register
   logic            in_v_ff;
   logic [7:0]      in_byte_ff;
   logic            in_start_ff;
   // parse state register
   parse_state_type st_ff;
   parse_state_type st_in;
   event_type       ev;
   // result register
   logic            out_v_ff;
   logic [2:0]      ev_ff;
   logic [9:0]      code_ff;
   logic [30:0]     clen_ff;
   logic [1:0]      body_ff;
   logic            keep_ff;
   logic [16:0]     count_ff;
   logic            advance;

   // the step fires when the result register is free or draining this cycle
   assign advance   = in_v_ff && (!out_v_ff || rsp_ready);
   assign req_ready = !in_v_ff || advance;
   assign limit     = (max_head_ff > LIMIT_CAP) ? LIMIT_CAP : max_head_ff;

   hrhp_step u_step (
      .cur_st (st_ff),
      .c      (in_byte_ff),
      .start  (in_start_ff),
      .limit  (limit),
      .nxt_st (st_in),
      .ev     (ev)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_head_ff <= MAX_HEAD_RESET;
         in_v_ff     <= 1'b0;
         out_v_ff    <= 1'b0;
         st_ff.phase <= PH_H;
         st_ff.flags <= 3'b111;
         st_ff.field_len <= '0;
         st_ff.ver_len <= '0;
         st_ff.code  <= '0;
         st_ff.clen  <= '0;
         st_ff.count <= '0;
         st_ff.body  <= BODY_NONE;
         st_ff.keep  <= 1'b0;
      end else begin
         if (csr_write_enable) max_head_ff <= csr_write_data;
         if (req_ready) in_v_ff <= req_valid;
         if (advance) begin
            st_ff    <= st_in;
            out_v_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff  <= req_in_byte;
         in_start_ff <= req_start_message;
      end
      if (advance) begin
         ev_ff    <= ev;
         code_ff  <= st_in.code;
         clen_ff  <= st_in.clen;
         body_ff  <= st_in.body;
         keep_ff  <= st_in.keep;
         count_ff <= st_in.count;
      end
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_event_res      = ev_ff;
   assign rsp_resp_code      = code_ff;
   assign rsp_length_value   = clen_ff;
   assign rsp_body_kind      = body_ff;
   assign rsp_keep_alive     = keep_ff;
   assign rsp_head_length    = count_ff;
endmodule

// File: hdl/hrhp_checker.sv
// Port-level checker for http_response_head_parser, bound to the top level.
// Depends on hrhp_pkg.
module hrhp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_event_res,
   input logic [1:0]  rsp_body_kind
);
   import hrhp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_evt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_res <= 3'(EV_ERROR))
      else $error("bad event code");

   a_body_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_body_kind != 2'd3)
      else $error("bad body kind");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");
endmodule

bind http_response_head_parser hrhp_checker u_hrhp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_event_res (rsp_event_res),
   .rsp_body_kind (rsp_body_kind)
);

// File: dv/http_response_head_parser_tb.sv
// Testbench for http_response_head_parser: streams random and directed response heads
// byte by byte and checks each result against an in-bench parser model.
// Depends on hrhp_pkg and the RTL of http_response_head_parser.
`timescale 1ns / 1ps

module http_response_head_parser_tb;
   import hrhp_pkg::*;

   // ---------------------------------------------------------------- clock, reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- DUT ports
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_start_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [9:0]  rsp_resp_code;
   logic [30:0] rsp_length_value;
   logic [1:0]  rsp_body_kind;
   logic        rsp_keep_alive;
   logic [16:0] rsp_head_length;
   logic        csr_write_enable = 1'b0;
   logic [16:0] csr_write_data = 17'd0;

   http_response_head_parser dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .req_start_message  (req_start_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_res      (rsp_event_res),
      .rsp_resp_code      (rsp_resp_code),
      .rsp_length_value   (rsp_length_value),
      .rsp_body_kind      (rsp_body_kind),
      .rsp_keep_alive     (rsp_keep_alive),
      .rsp_head_length    (rsp_head_length),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   // ---------------------------------------------------------------- types, queues
   typedef struct {
      logic [7:0] ch;
      logic       restart;
   } head_byte_type;

   typedef struct {
      event_type   ev;
      logic [9:0]  code;
      logic [30:0] clen;
      logic [1:0]  body;
      logic        keep;
      logic [16:0] hlen;
   } parse_result_type;

   head_byte_type    bytes_to_send[$];
   parse_result_type results_due[$];
   bit               failed = 1'b0;

   // ---------------------------------------------------------------- parser model state
   phase_type   ph;
   logic [2:0]  cand;           // candidate header names still matching
   int unsigned fld_len;
   int unsigned ver_len;
   int unsigned code_acc;
   int unsigned len_acc;
   int unsigned nbytes;
   logic [1:0]  body;
   logic        keep;
   int unsigned byte_limit = 4096;

   function automatic logic [7:0] fold_case(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic void clear_head();
      ph = PH_H;
      cand = 3'b111;
      fld_len = 0;
      ver_len = 0;
      code_acc = 0;
      len_acc = 0;
      nbytes = 0;
      body = BODY_NONE;
      keep = 1'b0;
   endfunction

   // one more byte of a header name; narrows the candidate set
   function automatic void take_name_char(logic [7:0] c);
      string names[3];
      logic [2:0] f;
      names[CAND_CONN] = "connection";
      names[CAND_CLEN] = "content-length";
      names[CAND_TENC] = "transfer-encoding";
      f = 3'b000;
      for (int k = 0; k < 3; k++)
         if (cand[k] && fld_len < names[k].len() && fold_case(c) == names[k][fld_len])
            f[k] = 1'b1;
      cand = f;
      if (fld_len < 32'h1FFFF) fld_len++;
   endfunction

   // one value byte; returns 0 on a bad Content-Length byte
   function automatic bit take_value_char(logic [7:0] c);
      int unsigned d;
      if (c == 8'd13) begin
         ph = PH_HDR_LF;
         return 1'b1;
      end
      if (fld_len < 32'h1FFFF) fld_len++;
      if (cand[CAND_CLEN]) begin
         if (c < "0" || c > "9") return 1'b0;
         d = c - "0";
         if (len_acc > (32'd2147483647 - d) / 10) return 1'b0;
         len_acc = len_acc * 10 + d;
      end
      return 1'b1;
   endfunction

   function automatic event_type parse_char(logic [7:0] c);
      bit dig;
      logic [2:0] f;
      dig = (c >= "0" && c <= "9");
      case (ph)
         PH_H: begin
            if (fold_case(c) != "h") return EV_ERROR;
            ph = PH_T1;
         end
         PH_T1: begin
            if (fold_case(c) != "t") return EV_ERROR;
            ph = PH_T2;
         end
         PH_T2: begin
            if (fold_case(c) != "t") return EV_ERROR;
            ph = PH_P;
         end
         PH_P: begin
            if (fold_case(c) != "p") return EV_ERROR;
            ph = PH_SLASH;
         end
         PH_SLASH: begin
            if (c != "/") return EV_ERROR;
            ver_len = 5;
            ph = PH_VER_FIRST;
         end
         PH_VER_FIRST, PH_VER: begin
            if (c == " " && ph == PH_VER) begin
               ph = PH_CODE_FIRST;
               return EV_MORE;
            end
            if (!dig && c != ".") return EV_ERROR;
            if (ver_len < 32'h1FFFF) ver_len++;
            ph = PH_VER;
         end
         PH_CODE_FIRST, PH_CODE: begin
            if (c == " " && ph == PH_CODE) begin
               ph = PH_REASON;
               return EV_MORE;
            end
            if (!dig) return EV_ERROR;
            code_acc = code_acc * 10 + (c - "0");
            if (code_acc > 1000) code_acc = 1000;
            ph = PH_CODE;
         end
         PH_REASON: begin
            if (c == 8'd13) ph = PH_LINE_LF;
         end
         PH_LINE_LF: begin
            if (c != 8'd10 || ver_len < 8) return EV_ERROR;
            if (code_acc < 1 || code_acc > 999) return EV_ERROR;
            ph = PH_HDR_START;
            return EV_STATUS;
         end
         PH_HDR_START: begin
            if (c == 8'd13) begin
               ph = PH_END_LF;
               return EV_MORE;
            end
            if (c < 32 || c > 126) return EV_ERROR;
            cand = 3'b111;
            fld_len = 0;
            take_name_char(c);   // a leading colon counts as a name byte
            ph = PH_NAME;
         end
         PH_NAME: begin
            if (c < 32 || c > 126) return EV_ERROR;
            if (c == ":") begin
               f = 3'b000;
               if (cand[CAND_CONN] && fld_len == 10) f = 3'b001;
               if (cand[CAND_CLEN] && fld_len == 14) f = 3'b010;
               if (cand[CAND_TENC] && fld_len == 17) f = 3'b100;
               cand = f;
               fld_len = 0;
               if (cand[CAND_CLEN]) len_acc = 0;
               ph = PH_VAL_BEFORE;
            end else begin
               take_name_char(c);
            end
         end
         PH_VAL_BEFORE: begin
            if (c == " ") return EV_MORE;
            ph = PH_VAL;
            return take_value_char(c) ? EV_MORE : EV_ERROR;
         end
         PH_VAL: return take_value_char(c) ? EV_MORE : EV_ERROR;
         PH_HDR_LF: begin
            if (c != 8'd10) return EV_ERROR;
            if (cand[CAND_CONN] && fld_len > 5) keep = 1'b1;
            if (cand[CAND_CLEN]) begin
               if (fld_len == 0) return EV_ERROR;
               body = BODY_CLEN;
            end
            if (cand[CAND_TENC]) body = BODY_CHUNK;
            ph = PH_HDR_START;
            return EV_HEADER;
         end
         PH_END_LF: begin
            if (c != 8'd10) return EV_ERROR;
            ph = PH_DONE;
            return EV_DONE;
         end
         default: return EV_ERROR;
      endcase
      return EV_MORE;
   endfunction

   // full step for one transferred byte: restart, byte limit, sticky failure
   function automatic parse_result_type predict_head_byte(logic [7:0] c, logic restart);
      parse_result_type r;
      int unsigned lim;
      lim = (byte_limit > HEAD_BYTES_MAX_DEF) ? HEAD_BYTES_MAX_DEF : byte_limit;
      if (restart) clear_head();
      if (ph == PH_DONE || ph == PH_FAIL) begin
         r.ev = EV_ERROR;
      end else begin
         nbytes++;
         r.ev = parse_char(c);
         if (r.ev != EV_DONE && r.ev != EV_ERROR && nbytes >= lim) r.ev = EV_ERROR;
         if (r.ev == EV_ERROR) ph = PH_FAIL;
      end
      r.code = code_acc[9:0];
      r.clen = len_acc[30:0];
      r.body = body;
      r.keep = keep;
      r.hlen = nbytes[16:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- driver
   int  send_gap = 0;
   bit  send_burst = 1'b0;   // stretches with no idling

   always @(posedge clock) begin
      head_byte_type hb;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_ready)) begin
         if (req_valid) begin
            // transfer at this edge: predict it now
            results_due.push_back(predict_head_byte(req_in_byte, req_start_message));
            if ($urandom_range(0, 40) == 0) send_burst = !send_burst;
            send_gap = send_burst ? 0 : $urandom_range(0, 11);
         end
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (bytes_to_send.size() > 0) begin
            hb = bytes_to_send.pop_front();
            req_valid <= 1'b1;
            req_in_byte <= hb.ch;
            req_start_message <= hb.restart;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   int  recv_stall = 0;
   bit  recv_burst = 1'b0;

   always @(posedge clock) begin
      parse_result_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               $display("%0t: result with nothing expected, got event %0d", $time,
                        rsp_event_res);
               failed = 1'b1;
            end else begin
               e = results_due.pop_front();
               if (rsp_event_res !== e.ev) begin
                  $display("%0t: event exp %0d got %0d", $time, e.ev, rsp_event_res);
                  failed = 1'b1;
               end
               if (rsp_resp_code !== e.code) begin
                  $display("%0t: resp code exp %0d got %0d", $time, e.code,
                           rsp_resp_code);
                  failed = 1'b1;
               end
               if (rsp_length_value !== e.clen) begin
                  $display("%0t: length value exp %0d got %0d", $time, e.clen,
                           rsp_length_value);
                  failed = 1'b1;
               end
               if (rsp_body_kind !== e.body) begin
                  $display("%0t: body_kind exp %0d got %0d", $time, e.body, rsp_body_kind);
                  failed = 1'b1;
               end
               if (rsp_keep_alive !== e.keep) begin
                  $display("%0t: keep_alive exp %0d got %0d", $time, e.keep, rsp_keep_alive);
                  failed = 1'b1;
               end
               if (rsp_head_length !== e.hlen) begin
                  $display("%0t: head_length exp %0d got %0d", $time, e.hlen,
                           rsp_head_length);
                  failed = 1'b1;
               end
            end
            if ($urandom_range(0, 40) == 0) recv_burst = !recv_burst;
            recv_stall = recv_burst ? 0 : $urandom_range(0, 11);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus helpers
   string crlf;
   bit    start_pending = 1'b0;

   task automatic queue_text(string t);
      head_byte_type hb;
      for (int i = 0; i < t.len(); i++) begin
         hb.ch = t[i];
         hb.restart = start_pending;
         start_pending = 1'b0;
         bytes_to_send.push_back(hb);
      end
   endtask

   task automatic queue_message(string t);
      start_pending = 1'b1;
      queue_text(t);
   endtask

   function automatic string mix_case(string t);
      string o;
      o = t;
      for (int i = 0; i < o.len(); i++)
         if (o[i] >= "a" && o[i] <= "z" && $urandom_range(0, 1)) o[i] = o[i] - 8'd32;
      return o;
   endfunction

   function automatic string random_text(int n, bit name_safe);
      string o;
      logic [7:0] c;
      o = "";
      for (int i = 0; i < n; i++) begin
         c = $urandom_range(33, 126);
         if (name_safe && c == ":") c = "x";
         o = $sformatf("%s%c", o, c);
      end
      return o;
   endfunction

   function automatic string random_head();
      string h, v;
      int n, code;
      string vchars;
      vchars = "0123456789.";
      h = mix_case("http/");
      n = ($urandom_range(0, 9) < 2) ? $urandom_range(1, 2) : $urandom_range(3, 5);
      for (int i = 0; i < n; i++) h = $sformatf("%s%c", h, vchars[$urandom_range(0, 10)]);
      case ($urandom_range(0, 9))
         0: code = 0;
         1: code = 999;
         2: code = $urandom_range(1000, 99999);
         3: code = $urandom_range(1, 99);
         default: code = $urandom_range(100, 599);
      endcase
      h = $sformatf("%s %0d %s%s", h, code, random_text($urandom_range(0, 6), 0), crlf);
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 6))
            0, 1: begin
               case ($urandom_range(0, 7))
                  0: v = "2147483647";
                  1: v = "2147483648";
                  2: v = "";
                  3: v = "12a4";
                  default: v = $sformatf("%0d", $urandom_range(0, 999999));
               endcase
               h = {h, mix_case("content-length"), ":", (n > 2) ? "  " : " ", v, crlf};
            end
            2: h = {h, mix_case("transfer-encoding"), ": chunked", crlf};
            3: h = {h, mix_case("connection"), ": ",
                    $urandom_range(0, 1) ? "keep-alive" : "close", crlf};
            4: h = {h, $urandom_range(0, 1) ? "Content-Lengt" : "Connections",
                    ": 77", crlf};
            default: h = {h, random_text($urandom_range(1, 12), 1), ": ",
                          random_text($urandom_range(0, 10), 0), crlf};
         endcase
      end
      h = {h, crlf};
      // damage some heads: one random byte, or a cut short head
      if ($urandom_range(0, 5) == 0) h[$urandom_range(0, h.len() - 1)] = $urandom_range(0, 255);
      if ($urandom_range(0, 9) == 0) h = h.substr(0, $urandom_range(0, h.len() - 1));
      return h;
   endfunction

   task automatic queue_random_heads(int n_bytes);
      int goal;
      string noise;
      goal = bytes_to_send.size() + n_bytes;
      while (bytes_to_send.size() < goal) begin
         if ($urandom_range(0, 11) == 0) begin
            // raw noise, with or without a restart on its first byte
            start_pending = $urandom_range(0, 1);
            noise = "";
            for (int i = 0; i < $urandom_range(1, 6); i++)
               noise = $sformatf("%s%c", noise, $urandom_range(0, 255));
            queue_text(noise);
         end else begin
            queue_message(random_head());
            if ($urandom_range(0, 7) == 0) queue_text("zz");   // bytes after the end
         end
      end
   endtask

   task automatic wait_idle();
      while (bytes_to_send.size() > 0 || req_valid || results_due.size() > 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_limit(int unsigned v);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v[16:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      byte_limit = v;
   endtask

   // ---------------------------------------------------------------- main sequence
   initial begin
      string hd;
      crlf = $sformatf("%c%c", 13, 10);
      clear_head();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: clean head with all three known headers, then the edge cases
      hd = {"HTTP/1.1 200 OK", crlf, "Content-Length: 2147483647", crlf,
            "transfer-encoding: chunked", crlf, "CONNECTION: keep-alive", crlf, crlf};
      queue_message(hd);
      queue_text({8'h00, 8'hFF});                          // after completion
      queue_message({"HTTP/1. 200 x", crlf});              // version too short
      queue_message({"HTTP/1.1 200", crlf});               // CR right after code
      queue_message({"HTTP/1.1 1000 x", crlf});            // code saturated
      queue_message({"HTTP/1.1 0 x", crlf});
      queue_message({"HTTP/1.1 999 x", crlf, ":a: 1", crlf,
                     "Content-Length: 2147483648", crlf}); // leading colon, overflow
      queue_message({"HTTP/1.1 204 x", crlf, "Content-Length:", crlf});   // empty value
      wait_idle();

      queue_random_heads(140);
      wait_idle();
      write_limit(16);                                     // smallest limit
      queue_message({"HTTP/1.1 200 OK", crlf, crlf});
      queue_random_heads(140);
      wait_idle();
      write_limit(17'h1FFFF);                              // above the cap
      queue_random_heads(140);
      wait_idle();
      write_limit(65536);
      queue_random_heads(140);
      wait_idle();
      write_limit($urandom_range(40, 300));
      queue_random_heads(140);
      wait_idle();

      if (!failed) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // ---------------------------------------------------------------- watchdog
   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// File: files.f
hdl/hrhp_pkg.sv
hdl/hrhp_step.sv
hdl/http_response_head_parser.sv
hdl/hrhp_checker.sv
dv/http_response_head_parser_tb.sv
